/* hw/rtl/pptp_ghe_pkg.sv */
// Shared types, field constants and codes for the PPTP GRE header engine.
`default_nettype none

package pptp_ghe_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_TX      = 2'd1;
    localparam logic [1:0] OP_RX_SYNC = 2'd2;
    localparam logic [1:0] OP_TX_SYNC = 2'd3;

    // Result status codes carried in the output tuser.
    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_ACK_ONLY   = 3'd1;
    localparam logic [2:0] ST_MALFORMED  = 3'd2;
    localparam logic [2:0] ST_OTHER_CALL = 3'd3;
    localparam logic [2:0] ST_TX_DONE    = 3'd4;

    // Header lengths in bytes, with and without the acknowledgement word.
    localparam logic [4:0] HDR_LEN_ACK    = 5'd16;
    localparam logic [4:0] HDR_LEN_NO_ACK = 5'd12;

    // Enhanced GRE constants.
    localparam logic [15:0] GRE_PROTO = 16'h880B;
    localparam logic [6:0]  GRE_VER   = 7'h01;

    // Bit positions in the flags byte and the version byte.
    localparam int FL_C_BIT  = 7;
    localparam int FL_R_BIT  = 6;
    localparam int FL_K_BIT  = 5;
    localparam int FL_S_BIT  = 4;
    localparam int VER_A_BIT = 7;

    // Flags byte of every transmitted header: K and S set.
    localparam logic [7:0] TX_FLAGS = 8'h30;

    // Configuration register indexes.
    localparam logic REG_LOCAL_CALL_ID = 1'b0;
    localparam logic REG_PEER_CALL_ID  = 1'b1;

    typedef struct packed {
        logic [15:0] local_call_id;
        logic [15:0] peer_call_id;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  in_flags;
        logic [7:0]  in_ver;
        logic [15:0] in_protocol;
        logic [15:0] in_payload_len;
        logic [15:0] in_call_id;
        logic [31:0] in_seq;
        logic [31:0] in_ack;
    } t_hdr_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  hdr_bytes;
        logic [7:0]  out_flags;
        logic [7:0]  out_ver;
        logic [15:0] out_protocol;
        logic [15:0] out_payload_len;
        logic [15:0] out_call_id;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic        ack_present;
        logic [31:0] peer_ack;
    } t_hdr_out;

endpackage

`default_nettype wire

/* hw/rtl/pptp_ghe_cfg.sv */
// APB register file holding the local and peer call ids.
`default_nettype none

module pptp_ghe_cfg
    import pptp_ghe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [15:0] r_local_call_id;
    logic [15:0] r_peer_call_id;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_call_id <= '0;
            r_peer_call_id  <= '0;
        end else if (wr_en) begin
            if (paddr[2] == REG_LOCAL_CALL_ID) begin
                r_local_call_id <= pwdata[15:0];
            end else begin
                r_peer_call_id <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LOCAL_CALL_ID: prdata = {16'd0, r_local_call_id};
            REG_PEER_CALL_ID:  prdata = {16'd0, r_peer_call_id};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.local_call_id = r_local_call_id;
    assign o_cfg.peer_call_id  = r_peer_call_id;

endmodule

`default_nettype wire

/* hw/rtl/pptp_ghe_core.sv */
// Call sequencing state and the single-pass header check and build logic.
`default_nettype none

module pptp_ghe_core
    import pptp_ghe_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_hdr_in i_item,
    input  wire t_cfg    i_cfg,
    output t_hdr_out     o_res
);

    logic [31:0] r_next_tx_seq;
    logic [31:0] r_last_rx_seq;
    logic [31:0] r_last_ack_sent;
    logic [31:0] r_highest_ack_rx;
    logic        r_first_packet;

    logic [31:0] n_next_tx_seq;
    logic [31:0] n_last_rx_seq;
    logic [31:0] n_last_ack_sent;
    logic [31:0] n_highest_ack_rx;
    logic        n_first_packet;

    logic [31:0] ack_word;
    logic [31:0] hi_max;
    logic [31:0] hi_taken;
    logic [31:0] hi_upd;
    logic [31:0] rx_expected;
    logic        in_order;
    logic        malformed;
    logic        other_call;
    logic        owe_ack;

    // The ack comes from the second word when S is set, else from the first.
    assign ack_word = i_item.in_flags[FL_S_BIT] ? i_item.in_ack : i_item.in_seq;
    assign hi_max   = (ack_word > r_highest_ack_rx) ? ack_word : r_highest_ack_rx;
    // A small ack replaces a held value near the top of the range (wrap).
    assign hi_taken = ((ack_word[31:8] == 24'd0) && (hi_max[31:8] == 24'hFFFFFF))
                      ? ack_word : hi_max;
    assign hi_upd   = i_item.in_ver[VER_A_BIT] ? hi_taken : r_highest_ack_rx;

    assign rx_expected = r_last_rx_seq + 32'd1;
    assign in_order    = (i_item.in_seq == rx_expected);

    assign malformed  = (i_item.in_ver[6:0] != GRE_VER)
                     || (i_item.in_protocol != GRE_PROTO)
                     || i_item.in_flags[FL_C_BIT]
                     || i_item.in_flags[FL_R_BIT]
                     || !i_item.in_flags[FL_K_BIT]
                     || (i_item.in_flags[3:0] != 4'd0);
    assign other_call = (i_item.in_call_id != i_cfg.local_call_id);
    assign owe_ack    = (r_last_ack_sent != r_last_rx_seq);

    always_comb begin
        o_res            = '0;
        n_next_tx_seq    = r_next_tx_seq;
        n_last_rx_seq    = r_last_rx_seq;
        n_last_ack_sent  = r_last_ack_sent;
        n_highest_ack_rx = r_highest_ack_rx;
        n_first_packet   = r_first_packet;
        case (i_item.op)
            OP_RX: begin
                if (malformed) begin
                    o_res.status = ST_MALFORMED;
                end else if (other_call) begin
                    o_res.status = ST_OTHER_CALL;
                end else begin
                    n_highest_ack_rx = hi_upd;
                    if (!i_item.in_flags[FL_S_BIT]) begin
                        o_res.status = ST_ACK_ONLY;
                    end else begin
                        o_res.status    = ST_ACCEPTED;
                        o_res.hdr_bytes = i_item.in_ver[VER_A_BIT] ? HDR_LEN_ACK
                                                                    : HDR_LEN_NO_ACK;
                        if (r_first_packet || in_order) begin
                            n_first_packet = 1'b0;
                            n_last_rx_seq  = i_item.in_seq;
                        end
                    end
                end
            end
            OP_TX: begin
                o_res.status          = ST_TX_DONE;
                o_res.hdr_bytes       = owe_ack ? HDR_LEN_ACK : HDR_LEN_NO_ACK;
                o_res.out_flags       = TX_FLAGS;
                o_res.out_ver         = {owe_ack, GRE_VER};
                o_res.out_protocol    = GRE_PROTO;
                o_res.out_payload_len = i_item.in_payload_len;
                o_res.out_call_id     = i_cfg.peer_call_id;
                o_res.out_seq         = r_next_tx_seq;
                o_res.out_ack         = owe_ack ? r_last_rx_seq : 32'd0;
                o_res.ack_present     = owe_ack;
                n_last_ack_sent       = r_last_rx_seq;
                n_next_tx_seq         = r_next_tx_seq + 32'd1;
            end
            OP_RX_SYNC: begin
                o_res.status     = ST_ACCEPTED;
                n_highest_ack_rx = hi_upd;
                if (in_order) begin
                    n_last_rx_seq = i_item.in_seq;
                end
            end
            OP_TX_SYNC: begin
                o_res.status    = ST_TX_DONE;
                n_last_ack_sent = r_last_rx_seq;
                n_next_tx_seq   = r_next_tx_seq + 32'd1;
            end
            default: begin
                o_res.status = ST_MALFORMED;
            end
        endcase
        o_res.peer_ack = n_highest_ack_rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_tx_seq    <= 32'd1;
            r_last_rx_seq    <= '0;
            r_last_ack_sent  <= '0;
            r_highest_ack_rx <= '0;
            r_first_packet   <= 1'b1;
        end else if (i_step) begin
            r_next_tx_seq    <= n_next_tx_seq;
            r_last_rx_seq    <= n_last_rx_seq;
            r_last_ack_sent  <= n_last_ack_sent;
            r_highest_ack_rx <= n_highest_ack_rx;
            r_first_packet   <= n_first_packet;
        end
    end

    a_tx_seq_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_item.op == OP_TX || i_item.op == OP_TX_SYNC)
        |=> r_next_tx_seq == $past(r_next_tx_seq) + 32'd1)
        else $error("transmit sequence did not advance by one");

    a_ack_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_item.op == OP_TX || i_item.op == OP_TX_SYNC)
        |=> r_last_ack_sent == r_last_rx_seq)
        else $error("owed acknowledgement not cleared by transmit");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_last_rx_seq) && $stable(r_highest_ack_rx)
                    && $stable(r_next_tx_seq))
        else $error("sequence state changed without an item");

endmodule

`default_nettype wire

/* hw/rtl/pptp_ghe_top_unused_guard.sv */
// Output holding register with a one-entry stage for the header engine results.
`default_nettype none

module pptp_ghe_out_stage
    import pptp_ghe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_load,
    input  wire t_hdr_out i_res,
    input  wire logic     i_ready,
    output logic          o_valid,
    output t_hdr_out      o_res
);

    logic     r_valid;
    t_hdr_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |-> !i_load)
        else $error("pending result overwritten before it was taken");

endmodule

`default_nettype wire

/* hw/rtl/pptp_gre_header_engine_unit.sv */
// Top level of the PPTP enhanced GRE header engine: stream ports, APB port, pipeline.
`default_nettype none

// An item is registered in the input register, then its result in the result register;
// it moves on only while the result register is empty or is being emptied.
// Throughput: one item per cycle; the input register refills in the same cycle that
// its item moves on. Input stalls only while a result waits with m_axis_tready low.
// Reset (synchronous, active low) empties both stages, clears the call ids and
// restores the sequence state: next transmit sequence 1, all others 0, first packet set.

module pptp_gre_header_engine_unit
    import pptp_ghe_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    // Input header items.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata, lowest bit up: in_flags[7:0], in_ver[15:8], in_protocol[31:16],
    // in_payload_len[47:32], in_call_id[63:48], in_seq[95:64], in_ack[127:96]
    input  wire logic [127:0] s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]   s_axis_tuser,

    // Result items.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata, lowest bit up: hdr_bytes[4:0], out_flags[12:5], out_ver[20:13],
    // out_protocol[36:21], out_payload_len[52:37], out_call_id[68:53],
    // out_seq[100:69], out_ack[132:101], ack_present[133], peer_ack[165:134],
    // zero fill[167:166]
    output logic [167:0]      m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]        m_axis_tuser,

    // Configuration: local_call_id at 0x0, peer_call_id at 0x4.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg     cfg;
    t_hdr_in  r_in;
    logic     r_in_valid;
    logic     in_take;
    logic     step;
    t_hdr_out core_res;
    t_hdr_out out_res;
    logic     out_valid;

    pptp_ghe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The item in the input register moves on, and commits its state update,
    // whenever the result register is empty or is being emptied this cycle.
    assign step          = r_in_valid && (!out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload register needs no reset; it is qualified by r_in_valid.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.op             <= s_axis_tuser;
            r_in.in_flags       <= s_axis_tdata[7:0];
            r_in.in_ver         <= s_axis_tdata[15:8];
            r_in.in_protocol    <= s_axis_tdata[31:16];
            r_in.in_payload_len <= s_axis_tdata[47:32];
            r_in.in_call_id     <= s_axis_tdata[63:48];
            r_in.in_seq         <= s_axis_tdata[95:64];
            r_in.in_ack         <= s_axis_tdata[127:96];
        end
    end

    // Checks, header build and the sequence state live in the core. The state
    // only changes when an item steps, so the next item always sees it updated.
    pptp_ghe_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    pptp_ghe_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (core_res),
        .i_ready (m_axis_tready),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tuser  = out_res.status;
    assign m_axis_tdata  = {2'b00,
                            out_res.peer_ack,
                            out_res.ack_present,
                            out_res.out_ack,
                            out_res.out_seq,
                            out_res.out_call_id,
                            out_res.out_payload_len,
                            out_res.out_protocol,
                            out_res.out_ver,
                            out_res.out_flags,
                            out_res.hdr_bytes};

    a_moves_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_valid |=> out_valid)
        else $error("item stuck in input register with result stage free");

    a_tx_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && (r_in.op == OP_TX || r_in.op == OP_TX_SYNC)
        |=> m_axis_tvalid && m_axis_tuser == ST_TX_DONE)
        else $error("transmit item did not report transmit done");

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the PPTP enhanced GRE header engine.
`default_nettype none

module tb;
    import pptp_ghe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog ends the run after this many cycles in which nothing moves.
    localparam int STALL_LIMIT = 1000;

    // An ack whose upper 24 bits are zero may follow one whose upper 24 bits
    // are all ones: the peer's 32-bit counter wrapped.
    localparam logic [31:0] ACK_WRAP_MASK = 32'hFFFF_FF00;

    // Flags and version bytes used to build well-formed received headers.
    localparam logic [7:0] FLAGS_K_S = 8'h30;
    localparam logic [7:0] FLAGS_K   = 8'h20;
    localparam logic [7:0] VER_ACK   = 8'h81;
    localparam logic [7:0] VER_PLAIN = 8'h01;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [127:0]   s_axis_tdata;
    logic [1:0]     s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [167:0]   m_axis_tdata;
    logic [2:0]     m_axis_tuser;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    pptp_gre_header_engine_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow of the call state, advanced once per accepted input item.
    logic [15:0] cfg_local_id;
    logic [15:0] cfg_peer_id;
    logic [31:0] tx_seq_next;
    logic [31:0] rx_seq_last;
    logic [31:0] ack_sent_last;
    logic [31:0] peer_ack_high;
    logic        rx_first;

    // Expected result items, oldest first.
    t_hdr_out pending_results[$];

    int  n_errors = 0;
    int  idle_cycles = 0;
    // When clear, neither side inserts gaps or stalls.
    bit  idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Prints one line per problem and keeps count of them.
    task automatic report_error(input string msg);
        n_errors++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Ack tracking shared by the checked and the unchecked receive paths.
    // The wrap test deliberately looks at the already updated high mark.
    function automatic void track_peer_ack(input t_hdr_in h);
        logic [31:0] ack_word;
        if (h.in_ver[VER_A_BIT]) begin
            ack_word = h.in_flags[FL_S_BIT] ? h.in_ack : h.in_seq;
            if (ack_word > peer_ack_high)
                peer_ack_high = ack_word;
            if ((ack_word & ACK_WRAP_MASK) == 32'd0 &&
                (peer_ack_high & ACK_WRAP_MASK) == ACK_WRAP_MASK)
                peer_ack_high = ack_word;
        end
    endfunction

    // Computes the result item for one header and advances the call state.
    function automatic t_hdr_out predict_header(input t_hdr_in h);
        t_hdr_out r;
        logic     owe;
        r = '0;
        case (h.op)
            OP_RX: begin
                if (h.in_ver[6:0] != GRE_VER || h.in_protocol != GRE_PROTO ||
                    h.in_flags[FL_C_BIT] || h.in_flags[FL_R_BIT] ||
                    !h.in_flags[FL_K_BIT] || h.in_flags[3:0] != 4'h0) begin
                    r.status = ST_MALFORMED;
                end else if (h.in_call_id != cfg_local_id) begin
                    r.status = ST_OTHER_CALL;
                end else begin
                    track_peer_ack(h);
                    if (!h.in_flags[FL_S_BIT]) begin
                        r.status = ST_ACK_ONLY;
                    end else begin
                        r.status = ST_ACCEPTED;
                        r.hdr_bytes = h.in_ver[VER_A_BIT] ? HDR_LEN_ACK : HDR_LEN_NO_ACK;
                        // Out-of-order payload is still accepted but not tracked.
                        if (rx_first || h.in_seq == rx_seq_last + 32'd1) begin
                            rx_first = 1'b0;
                            rx_seq_last = h.in_seq;
                        end
                    end
                end
            end
            OP_TX: begin
                owe = (ack_sent_last != rx_seq_last);
                r.status = ST_TX_DONE;
                r.hdr_bytes = owe ? HDR_LEN_ACK : HDR_LEN_NO_ACK;
                r.out_flags = TX_FLAGS;
                r.out_ver = {owe, GRE_VER};
                r.out_protocol = GRE_PROTO;
                r.out_payload_len = h.in_payload_len;
                r.out_call_id = cfg_peer_id;
                r.out_seq = tx_seq_next;
                r.out_ack = owe ? rx_seq_last : 32'd0;
                r.ack_present = owe;
                ack_sent_last = rx_seq_last;
                tx_seq_next = tx_seq_next + 32'd1;
            end
            OP_RX_SYNC: begin
                // No checks, and the first-packet flag is left alone.
                track_peer_ack(h);
                if (h.in_seq == rx_seq_last + 32'd1)
                    rx_seq_last = h.in_seq;
                r.status = ST_ACCEPTED;
            end
            default: begin
                ack_sent_last = rx_seq_last;
                tx_seq_next = tx_seq_next + 32'd1;
                r.status = ST_TX_DONE;
            end
        endcase
        r.peer_ack = peer_ack_high;
        return r;
    endfunction

    function automatic t_hdr_in make_hdr(input logic [1:0] op, input logic [7:0] flags,
                                         input logic [7:0] ver, input logic [15:0] proto,
                                         input logic [15:0] plen, input logic [15:0] cid,
                                         input logic [31:0] seq, input logic [31:0] ack);
        t_hdr_in h;
        h.op = op;
        h.in_flags = flags;
        h.in_ver = ver;
        h.in_protocol = proto;
        h.in_payload_len = plen;
        h.in_call_id = cid;
        h.in_seq = seq;
        h.in_ack = ack;
        return h;
    endfunction

    // Draws one header. Half are well-formed receive headers, mostly for this call
    // and mostly in sequence, so that the tracking state keeps moving; the rest
    // are transmits, sync updates, single-field corruptions and raw noise.
    function automatic t_hdr_in random_hdr();
        t_hdr_in     h;
        int unsigned pick;
        int unsigned ack_pick;
        int unsigned seq_pick;
        pick = $urandom_range(0, 99);
        ack_pick = $urandom_range(0, 3);
        seq_pick = $urandom_range(0, 9);
        h.op = OP_RX;
        h.in_flags = $urandom_range(0, 1) ? FLAGS_K_S : FLAGS_K;
        h.in_ver = $urandom_range(0, 1) ? VER_ACK : VER_PLAIN;
        h.in_protocol = GRE_PROTO;
        h.in_payload_len = 16'($urandom);
        h.in_call_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cfg_local_id;
        case (seq_pick)
            0, 1:    h.in_seq = $urandom;
            2:       h.in_seq = rx_seq_last;
            default: h.in_seq = rx_seq_last + 32'd1;
        endcase
        case (ack_pick)
            0: h.in_ack = peer_ack_high + 32'($urandom_range(0, 50));
            1: h.in_ack = $urandom;
            2: h.in_ack = 32'($urandom_range(0, 255));
            default: h.in_ack = ACK_WRAP_MASK | 32'($urandom_range(0, 255));
        endcase
        // With S clear the ack travels in the sequence word.
        if (!h.in_flags[FL_S_BIT] && $urandom_range(0, 1))
            h.in_seq = h.in_ack;
        if (pick < 50) begin
            // Well-formed receive header, as drawn above.
        end else if (pick < 65) begin
            h.op = OP_TX;
        end else if (pick < 72) begin
            h.op = OP_RX_SYNC;
            h.in_flags = 8'($urandom);
            h.in_ver = 8'($urandom);
        end else if (pick < 78) begin
            h.op = OP_TX_SYNC;
        end else if (pick < 88) begin
            case ($urandom_range(0, 5))
                0: h.in_ver[6:0] = 7'($urandom);
                1: h.in_protocol = 16'($urandom);
                2: h.in_flags[FL_C_BIT] = 1'b1;
                3: h.in_flags[FL_R_BIT] = 1'b1;
                4: h.in_flags[FL_K_BIT] = 1'b0;
                default: h.in_flags[3:0] = 4'($urandom);
            endcase
        end else begin
            h = make_hdr(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), $urandom, $urandom);
        end
        return h;
    endfunction

    // Sends one header item and records its expected result on acceptance.
    task automatic send_hdr(input t_hdr_in h);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= h.op;
        s_axis_tdata <= {h.in_ack, h.in_seq, h.in_call_id, h.in_payload_len,
                         h.in_protocol, h.in_ver, h.in_flags};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_header(h));
    endtask

    // Stops sending and waits until every expected result has come back,
    // then idles on so that the two-stage pipeline settles.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes one call id register over APB; only called with the block idle.
    task automatic write_call_id(input logic reg_idx, input logic [15:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_LOCAL_CALL_ID)
            cfg_local_id = value;
        else
            cfg_peer_id = value;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_hdr(random_hdr());
    endtask

    // Hand-picked headers: sequence and ack wrap, every malformation, the
    // other-call case, ack-only headers and all four operations.
    task automatic test_directed_headers();
        logic [15:0] lid;
        lid = 16'h1234;
        write_call_id(REG_LOCAL_CALL_ID, lid);
        write_call_id(REG_PEER_CALL_ID, 16'hBEEF);
        // Nothing received yet, so no ack is owed.
        send_hdr(make_hdr(OP_TX, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 0, 0));
        // The first payload header is taken whatever its sequence number.
        send_hdr(make_hdr(OP_RX, FLAGS_K_S, VER_PLAIN, GRE_PROTO, 16'hFFFF, lid,
                          32'hFFFF_FFFE, 32'h0));
        send_hdr(make_hdr(OP_RX, FLAGS_K_S, VER_ACK, GRE_PROTO, 16'h0040, lid,
                          32'hFFFF_FFFF, 32'hFFFF_FF80));
        // Receive sequence wraps to zero and the peer's ack wraps too.
        send_hdr(make_hdr(OP_RX, FLAGS_K_S, VER_ACK, GRE_PROTO, 16'h0000, lid,
                          32'h0, 32'h0000_0010));
        send_hdr(make_hdr(OP_TX, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Out of order: accepted, state kept.
        send_hdr(make_hdr(OP_RX, FLAGS_K_S, VER_PLAIN, GRE_PROTO, 16'h0100, lid, 5, 0));
        send_hdr(make_hdr(OP_RX, FLAGS_K_S, VER_PLAIN, GRE_PROTO, 16'h0100, lid, 1, 0));
        // An ack is owed now.
        send_hdr(make_hdr(OP_TX, 8'h00, 8'h00, 16'h0000, 16'h1234, 16'h0000, 0, 0));
        // Ack-only headers, with and without the ack flag.
        send_hdr(make_hdr(OP_RX, FLAGS_K, VER_ACK, GRE_PROTO, 16'h0000, lid, 32'h20, 0));
        send_hdr(make_hdr(OP_RX, FLAGS_K, VER_PLAIN, GRE_PROTO, 16'h0000, lid, 32'h90, 0));
        // Each malformation on its own.
        send_hdr(make_hdr(OP_RX, FLAGS_K_S, 8'h02, GRE_PROTO, 16'h0, lid, 2, 32'h99));
        send_hdr(make_hdr(OP_RX, FLAGS_K_S, VER_ACK, 16'h0800, 16'h0, lid, 2, 32'h99));
        send_hdr(make_hdr(OP_RX, 8'hB0, VER_ACK, GRE_PROTO, 16'h0, lid, 2, 32'h99));
        send_hdr(make_hdr(OP_RX, 8'h70, VER_ACK, GRE_PROTO, 16'h0, lid, 2, 32'h99));
        send_hdr(make_hdr(OP_RX, 8'h10, VER_ACK, GRE_PROTO, 16'h0, lid, 2, 32'h99));
        send_hdr(make_hdr(OP_RX, 8'h3F, VER_ACK, GRE_PROTO, 16'h0, lid, 2, 32'h99));
        // Right shape, wrong call: the large ack must be ignored.
        send_hdr(make_hdr(OP_RX, FLAGS_K_S, VER_ACK, GRE_PROTO, 16'h0, 16'hFFFF, 2,
                          32'h7FFF_0000));
        // Sync updates, one with the ack carried in the sequence word.
        send_hdr(make_hdr(OP_RX_SYNC, FLAGS_K_S, VER_ACK, 16'h0, 16'h0, 16'h0, 2, 32'h30));
        send_hdr(make_hdr(OP_RX_SYNC, 8'h00, 8'h80, 16'h0, 16'h0, 16'h0, 32'h40, 32'h0));
        send_hdr(make_hdr(OP_TX_SYNC, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_hdr(make_hdr(OP_TX, 8'h00, 8'h00, 16'h0000, 16'h0001, 16'h0000, 0, 0));
        send_hdr(make_hdr(OP_RX, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_hdr(make_hdr(OP_RX_SYNC, FLAGS_K_S, VER_ACK, 16'h0, 16'h0, 16'h0, 0,
                          32'hFFFF_FFFF));
        send_hdr(make_hdr(OP_RX_SYNC, FLAGS_K_S, VER_ACK, 16'h0, 16'h0, 16'h0, 0,
                          32'h0000_0005));
    endtask

    task automatic test_random_traffic();
        write_call_id(REG_LOCAL_CALL_ID, 16'($urandom));
        write_call_id(REG_PEER_CALL_ID, 16'($urandom));
        send_random(300);
    endtask

    // Call ids at both ends of their range, in both registers.
    task automatic test_call_id_extremes();
        write_call_id(REG_LOCAL_CALL_ID, 16'h0000);
        write_call_id(REG_PEER_CALL_ID, 16'hFFFF);
        send_random(150);
        write_call_id(REG_LOCAL_CALL_ID, 16'hFFFF);
        write_call_id(REG_PEER_CALL_ID, 16'h0000);
        send_random(150);
    endtask

    // Full rate on both sides: no gaps, no stalls.
    task automatic test_back_to_back();
        write_call_id(REG_LOCAL_CALL_ID, 16'($urandom));
        idle_on = 1'b0;
        send_random(200);
        drain();
        idle_on = 1'b1;
    endtask

    // Result side: while idle_on is set, may hold m_axis_tready low before each item.
    initial begin
        int unsigned stall;
        forever begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Compares each result item, field by field, with the oldest expectation.
    always @(posedge i_clk) begin
        t_hdr_out got;
        t_hdr_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.hdr_bytes = m_axis_tdata[4:0];
            got.out_flags = m_axis_tdata[12:5];
            got.out_ver = m_axis_tdata[20:13];
            got.out_protocol = m_axis_tdata[36:21];
            got.out_payload_len = m_axis_tdata[52:37];
            got.out_call_id = m_axis_tdata[68:53];
            got.out_seq = m_axis_tdata[100:69];
            got.out_ack = m_axis_tdata[132:101];
            got.ack_present = m_axis_tdata[133];
            got.peer_ack = m_axis_tdata[165:134];
            if (pending_results.size() == 0) begin
                report_error("result item arrived with nothing expected");
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(got.status), 32'(want.status));
                check_field("hdr_bytes", 32'(got.hdr_bytes), 32'(want.hdr_bytes));
                check_field("out_flags", 32'(got.out_flags), 32'(want.out_flags));
                check_field("out_ver", 32'(got.out_ver), 32'(want.out_ver));
                check_field("out_protocol", 32'(got.out_protocol), 32'(want.out_protocol));
                check_field("out_payload_len", 32'(got.out_payload_len),
                            32'(want.out_payload_len));
                check_field("out_call_id", 32'(got.out_call_id), 32'(want.out_call_id));
                check_field("out_seq", got.out_seq, want.out_seq);
                check_field("out_ack", got.out_ack, want.out_ack);
                check_field("ack_present", 32'(got.ack_present), 32'(want.ack_present));
                check_field("peer_ack", got.peer_ack, want.peer_ack);
            end
        end
    end

    // Watchdog: a long stretch with no handshake on any port means a hang.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        idle_on = 1'b1;
        // State after reset.
        cfg_local_id = 16'h0000;
        cfg_peer_id = 16'h0000;
        tx_seq_next = 32'd1;
        rx_seq_last = 32'd0;
        ack_sent_last = 32'd0;
        peer_ack_high = 32'd0;
        rx_first = 1'b1;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_RX;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_headers();
        test_random_traffic();
        test_call_id_extremes();
        test_back_to_back();
        drain();
        repeat (8) @(posedge i_clk);

        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* pptp_gre_header_engine_unit.f */
hw/rtl/pptp_ghe_pkg.sv
hw/rtl/pptp_ghe_cfg.sv
hw/rtl/pptp_ghe_core.sv
hw/rtl/pptp_ghe_top_unused_guard.sv
hw/rtl/pptp_gre_header_engine_unit.sv
test/tb.sv
